// ----- design/fwt_pkg.sv -----
// shared types and constants for the fenwick range-sum table
package fwt_pkg;

	localparam int DATA_W = 48;
	localparam int IDX_W = 11;
	localparam int IN_VALUE_W = 32;

	localparam int DEF_MAX_ELEMENTS = 1024;
	localparam int DEF_VALUE_BITS = 32;

	localparam logic [IDX_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic OP_SET = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic STAT_OK = 1'b0;
	localparam logic STAT_RANGE = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_READ,
		S_ACC,
		S_DELTA,
		S_UREAD,
		S_UWRITE,
		S_DONE
	} fwt_state_t;

endpackage

// ----- design/fenwick_range_sum_table_core.sv -----
// fenwick range-sum table: sequencer, shared 48-bit adder and node memory
//
// Command channel: an item (opcode, first_index, last_index, new_value) is taken
// on a clock edge with start high and busy low. busy stays high until the result
// has been shown. The result (range_total, status) sits on its ports for exactly
// one cycle while done is high; the receiver cannot stall it.
// A query reads prefix(last) and prefix(first-1); a set reads prefix(first) and
// prefix(first-1) to recover the old value, then adds the difference along the
// update path up to MAX_ELEMENTS. Every prefix node passes through a walk check,
// a registered memory read and the shared adder; every update node through a read,
// then an add and write back. An out-of-range item shows status 1 in the cycle
// right after it is taken.
// Reset clears all tree nodes in a pass over the MAX_ELEMENTS entries, one entry
// per cycle; busy is high during it. The configuration channel (cfg_valid,
// cfg_ready, cfg_data) sets element_count and is always ready; write it only
// while no item is in flight. Reset value of element_count is 1024.
module fenwick_range_sum_table_core
	import fwt_pkg::*;
#(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [IDX_W-1:0]             first_index,
	input  logic [IDX_W-1:0]             last_index,
	input  logic signed [IN_VALUE_W-1:0] new_value,
	output logic                         done,
	output logic signed [DATA_W-1:0]     range_total,
	output logic                         status,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [IDX_W-1:0]             cfg_data
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int IW = $clog2(MAX_ELEMENTS + 1) + 1;
	localparam int CW = (IW > IDX_W) ? IW : IDX_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);

	fwt_state_t state_q, state_d;

	logic [IDX_W-1:0]      count_q;
	logic                  op_q;
	logic                  stat_q;
	logic                  phase_q;
	logic [CW-1:0]         first_q;
	logic [CW-1:0]         walk_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [DATA_W-1:0]     acc_q;
	logic [DATA_W-1:0]     rdata_q;
	logic [AW-1:0]         clr_q;

	logic [DATA_W-1:0] mem [MAX_ELEMENTS];

	// combinational helpers
	logic [CW-1:0]     n_eff;
	logic [CW-1:0]     first_x;
	logic [CW-1:0]     last_x;
	logic              bad_item;
	logic [CW-1:0]     walk_m1;
	logic [CW-1:0]     low_bit;
	logic [CW-1:0]     walk_up;
	logic [CW-1:0]     walk_dn;
	logic [DATA_W-1:0] target;

	// shared adder
	logic [DATA_W-1:0] add_a;
	logic [DATA_W-1:0] add_b;
	logic              add_sub;
	logic [DATA_W-1:0] add_y;

	// memory port controls
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [DATA_W-1:0] mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	assign cfg_ready = 1'b1;

	assign n_eff = (CW'(count_q) > MAX_C) ? MAX_C : CW'(count_q);
	assign first_x = CW'(first_index);
	assign last_x = CW'(last_index);
	assign bad_item = (first_x == '0) || (first_x > n_eff) ||
		((opcode == OP_QUERY) && ((last_x == '0) || (last_x > n_eff)));

	assign walk_m1 = walk_q - CW'(1);
	assign low_bit = walk_q & (~walk_q + CW'(1));
	assign walk_up = walk_q + low_bit;
	assign walk_dn = walk_q - low_bit;
	assign target = {{(DATA_W - VALUE_BITS){val_q[VALUE_BITS-1]}}, val_q};

	assign add_y = add_a + (add_sub ? ~add_b : add_b) + DATA_W'(add_sub);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = bad_item ? S_DONE : S_CHECK;
			end
			S_CHECK: begin
				if (walk_q != '0) begin
					state_d = S_READ;
				end else if (phase_q) begin
					state_d = (op_q == OP_SET) ? S_DELTA : S_DONE;
				end
			end
			S_READ:   state_d = S_ACC;
			S_ACC:    state_d = S_CHECK;
			S_DELTA:  state_d = S_UREAD;
			S_UREAD:  state_d = S_UWRITE;
			S_UWRITE: state_d = (walk_up > MAX_C) ? S_DONE : S_UREAD;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs and unit controls
	always_comb begin
		busy = (state_q != S_IDLE);
		done = (state_q == S_DONE);
		range_total = (op_q == OP_SET) ? '0 : acc_q;
		status = stat_q;
		add_a = acc_q;
		add_b = rdata_q;
		add_sub = phase_q;
		mem_we = 1'b0;
		mem_wa = walk_m1[AW-1:0];
		mem_wd = add_y;
		mem_re = 1'b0;
		mem_ra = walk_m1[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			S_READ:  mem_re = 1'b1;
			S_DELTA: begin
				add_a = target;
				add_b = acc_q;
				add_sub = 1'b1;
			end
			S_UREAD: mem_re = 1'b1;
			S_UWRITE: begin
				add_a = rdata_q;
				add_b = acc_q;
				add_sub = 1'b0;
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			count_q <= COUNT_RESET;
			clr_q <= '0;
			op_q <= OP_QUERY;
			stat_q <= STAT_OK;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) count_q <= cfg_data;
			if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == S_IDLE && start) begin
				op_q <= opcode;
				stat_q <= bad_item ? STAT_RANGE : STAT_OK;
				phase_q <= 1'b0;
			end
			if (state_q == S_CHECK && walk_q == '0) phase_q <= 1'b1;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					first_q <= first_x;
					val_q <= new_value[VALUE_BITS-1:0];
					acc_q <= '0;
					walk_q <= (opcode == OP_SET) ? first_x : last_x;
				end
			end
			S_CHECK: begin
				// first walk done: start the prefix below first_index
				if (walk_q == '0 && !phase_q) walk_q <= first_q - CW'(1);
				if (walk_q == '0 && phase_q) walk_q <= first_q;
			end
			S_ACC: begin
				acc_q <= add_y;
				walk_q <= walk_dn;
			end
			S_DELTA:  acc_q <= add_y;
			S_UWRITE: walk_q <= walk_up;
			default: begin
			end
		endcase
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy item");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_bad_index: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && first_index == '0) |=> (done && status == STAT_RANGE))
		else $error("index zero not flagged at once");

	a_set_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == OP_SET) |-> (range_total == '0))
		else $error("set item returned a nonzero total");

endmodule

// ----- test/tb_top.sv -----
// testbench for the fenwick range-sum table core: directed and random items against a shadow model
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fwt_pkg::*;

	localparam int SLOTS = DEF_MAX_ELEMENTS;
	localparam int INDEX_SPAN = (1 << IDX_W) - 1;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 100;
	localparam int IDLE_PCT = 35;
	localparam int MAX_GAP = 80;

	typedef struct {
		logic signed [DATA_W-1:0] total;
		logic                     stat;
	} sum_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         opcode;
	logic [IDX_W-1:0]             first_index;
	logic [IDX_W-1:0]             last_index;
	logic signed [IN_VALUE_W-1:0] new_value;
	logic                         done;
	logic signed [DATA_W-1:0]     range_total;
	logic                         status;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [IDX_W-1:0]             cfg_data;

	// plain per-position values; the tree itself is the block's business
	logic [DATA_W-1:0] shadow_vals [1:SLOTS];
	logic [IDX_W-1:0]  shadow_count;
	sum_result_t       pending_sums [$];

	int  fail_count = 0;
	int  n_items = 0;
	int  n_sets = 0;
	int  n_queries = 0;
	int  n_rejects = 0;
	int  n_counts = 0;
	int  n_checked = 0;
	int  stall_cycles;
	bit  idle_enable = 1'b0;

	fenwick_range_sum_table_core #(
		.MAX_ELEMENTS(DEF_MAX_ELEMENTS),
		.VALUE_BITS(DEF_VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.first_index(first_index),
		.last_index(last_index),
		.new_value(new_value),
		.done(done),
		.range_total(range_total),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int active_slots();
		return (shadow_count > SLOTS) ? SLOTS : int'(shadow_count);
	endfunction

	function automatic logic [DATA_W-1:0] prefix_sum(int upto);
		logic [DATA_W-1:0] acc;
		acc = '0;
		for (int k = 1; k <= upto; k++)
			acc += shadow_vals[k];
		return acc;
	endfunction

	function automatic sum_result_t apply_item(logic op, logic [IDX_W-1:0] lo,
			logic [IDX_W-1:0] hi, logic signed [IN_VALUE_W-1:0] val);
		int          lim;
		sum_result_t r;
		lim = active_slots();
		r.total = '0;
		r.stat = STAT_OK;
		if (op == OP_SET) begin
			if (lo == 0 || lo > lim)
				r.stat = STAT_RANGE;
			else
				shadow_vals[lo] = {{(DATA_W-IN_VALUE_W){val[IN_VALUE_W-1]}}, val};
		end else begin
			if (lo == 0 || lo > lim || hi == 0 || hi > lim)
				r.stat = STAT_RANGE;
			else
				r.total = prefix_sum(int'(hi)) - prefix_sum(int'(lo) - 1);
		end
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] pick_index(int lim);
		if (lim == 0 || $urandom_range(99) < 12)
			return IDX_W'($urandom_range(0, INDEX_SPAN));
		return IDX_W'($urandom_range(1, lim));
	endfunction

	function automatic logic signed [IN_VALUE_W-1:0] pick_value();
		case ($urandom_range(4))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return int'($urandom_range(200)) - 100;
			default: return $urandom();
		endcase
	endfunction

	// one command beat; start is left high so a following item can go back to back
	task automatic send_item(logic op, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
			logic signed [IN_VALUE_W-1:0] val);
		int          gap;
		sum_result_t r;
		gap = 0;
		if (idle_enable && $urandom_range(99) < IDLE_PCT)
			gap = $urandom_range(1, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		first_index <= lo;
		last_index <= hi;
		new_value <= val;
		do @(posedge clk); while (busy);
		r = apply_item(op, lo, hi, val);
		pending_sums.insert(pending_sums.size(), r);
		n_items++;
		if (op == OP_SET)
			n_sets++;
		else
			n_queries++;
		if (r.stat == STAT_RANGE)
			n_rejects++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (pending_sums.size() != 0 || busy);
	endtask

	task automatic write_count(logic [IDX_W-1:0] cnt);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= cnt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_count = cnt;
		n_counts++;
	endtask

	task automatic test_reset_state();
		send_item(OP_QUERY, 11'd1, 11'd1024, '0);
		send_item(OP_QUERY, 11'd1024, 11'd1024, '0);
	endtask

	task automatic test_directed_edges();
		send_item(OP_SET, 11'd1, 11'd0, 32'sh7fff_ffff);
		send_item(OP_SET, 11'd1024, 11'd2047, 32'sh8000_0000);
		send_item(OP_SET, 11'd512, 11'd3, -32'sd1);
		// index zero and indices past the count are refused
		send_item(OP_SET, 11'd0, 11'd5, 32'sd99);
		send_item(OP_SET, 11'd1025, 11'd5, 32'sd99);
		send_item(OP_SET, 11'd2047, 11'd2047, 32'sd99);
		send_item(OP_QUERY, 11'd1, 11'd1024, '0);
		send_item(OP_QUERY, 11'd1, 11'd1, '0);
		// reversed range gives the negated sum between the ends
		send_item(OP_QUERY, 11'd1024, 11'd1, '0);
		send_item(OP_QUERY, 11'd600, 11'd300, '0);
		send_item(OP_QUERY, 11'd0, 11'd5, '0);
		send_item(OP_QUERY, 11'd5, 11'd0, '0);
		send_item(OP_QUERY, 11'd3, 11'd1025, '0);
		send_item(OP_QUERY, 11'd2047, 11'd2047, '0);
		send_item(OP_SET, 11'd1, 11'd0, 32'sh1234_5678);
		send_item(OP_QUERY, 11'd512, 11'd512, '0);
		send_item(OP_QUERY, 11'd2, 11'd1023, '0);
	endtask

	task automatic test_count_limits();
		write_count(11'd0);
		send_item(OP_SET, 11'd1, 11'd1, 32'sd5);
		send_item(OP_QUERY, 11'd1, 11'd1, '0);
		write_count(11'd1);
		send_item(OP_SET, 11'd1, 11'd1, 32'sd7);
		send_item(OP_QUERY, 11'd1, 11'd1, '0);
		send_item(OP_SET, 11'd2, 11'd1, 32'sd7);
		send_item(OP_QUERY, 11'd1, 11'd2, '0);
		// values above the table size are capped, stored values survive the change
		write_count(11'd2047);
		send_item(OP_QUERY, 11'd1, 11'd1024, '0);
		send_item(OP_SET, 11'd1025, 11'd1, 32'sd7);
		send_item(OP_QUERY, 11'd1024, 11'd1024, '0);
	endtask

	task automatic random_phase(int items, logic [IDX_W-1:0] cnt);
		int lim;
		write_count(cnt);
		lim = active_slots();
		for (int k = 0; k < items; k++) begin
			if ($urandom_range(99) < 2)
				wait_idle();
			send_item(logic'($urandom_range(1)), pick_index(lim), pick_index(lim),
				pick_value());
		end
	endtask

	task automatic test_random_mix();
		// long run with the sender adding no random idle gaps
		idle_enable = 1'b0;
		random_phase(120, 11'd1024);
		idle_enable = 1'b1;
		random_phase(160, IDX_W'($urandom_range(2, 16)));
		random_phase(120, 11'd2047);
		random_phase(160, IDX_W'($urandom_range(1, SLOTS)));
		random_phase(60, 11'd1);
		random_phase(80, 11'd1024);
	endtask

	task automatic finish_run();
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d items: %0d sets, %0d queries, %0d out of range, %0d count writes",
			n_items, n_sets, n_queries, n_rejects, n_counts);
		$display("compared %0d results with the shadow sums", n_checked);
		if (fail_count == 0 && pending_sums.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= OP_SET;
		first_index <= '0;
		last_index <= '0;
		new_value <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		for (int k = 1; k <= SLOTS; k++)
			shadow_vals[k] = '0;
		shadow_count = COUNT_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_directed_edges();
		test_count_limits();
		test_random_mix();
		finish_run();
	end

	always @(posedge clk) begin : check_results
		sum_result_t want;
		if (arst_n && done) begin
			if (pending_sums.size() == 0) begin
				$error("unexpected result: range_total %0d status %0d",
					range_total, status);
				fail_count++;
			end else begin
				want = pending_sums.pop_front();
				n_checked++;
				if (range_total !== want.total) begin
					$error("range_total: expected %0d, got %0d", want.total, range_total);
					fail_count++;
				end
				if (status !== want.stat) begin
					$error("status: expected %0d, got %0d", want.stat, status);
					fail_count++;
				end
			end
		end
	end

	// stall watchdog: any accepted beat restarts the count
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
